// ===== design/uer_pkg.sv =====
`default_nettype none
package uer_pkg;

	// Measurement phases, in the order one attempt passes through them.
	typedef enum logic [2:0] {
		PH_TRIG_LOW  = 3'd0,
		PH_TRIG_HIGH = 3'd1,
		PH_WAIT_RISE = 3'd2,
		PH_ECHO_HIGH = 3'd3,
		PH_GAP       = 3'd4
	} uer_phase_t;

	// Configuration register indexes.
	localparam logic [2:0] CFG_TRIG_LOW  = 3'd0;
	localparam logic [2:0] CFG_TRIG_HIGH = 3'd1;
	localparam logic [2:0] CFG_TIMEOUT   = 3'd2;
	localparam logic [2:0] CFG_GAP       = 3'd3;
	localparam logic [2:0] CFG_MAX_DIST  = 3'd4;

	// Register values after reset.
	localparam logic [15:0] RST_TRIG_LOW  = 16'd10000;
	localparam logic [15:0] RST_TRIG_HIGH = 16'd10;
	localparam logic [15:0] RST_TIMEOUT   = 16'd30000;
	localparam logic [15:0] RST_GAP       = 16'd50000;
	localparam logic [7:0]  RST_MAX_DIST  = 8'd200;

	// Echo width to distance: each tick of echo adds two, and every 59 of those make one centimetre.
	localparam logic [6:0] DIST_STEP    = 7'd2;
	localparam logic [6:0] DIST_DIVISOR = 7'd59;

	typedef struct packed {
		logic [15:0] trig_low;
		logic [15:0] trig_high;
		logic [15:0] timeout;
		logic [15:0] gap;
		logic [7:0]  max_dist;
	} uer_cfg_t;

	typedef struct packed {
		logic [7:0] mean_cm;
		logic       mean_valid;
		logic [7:0] reading_cm;
		logic       reading_kept;
		logic       reading_done;
		logic       trigger_level;
	} uer_result_t;

endpackage
`default_nettype wire

// ===== design/uer_sequencer.sv =====
`default_nettype none
module uer_sequencer #(
	parameter int SAMPLE_COUNT = 10
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 advance,
	input  wire                 echo_level,
	input  uer_pkg::uer_cfg_t   cfg,
	output uer_pkg::uer_result_t result
);

	// Mean by reciprocal multiplication: exact for sums below 2^12 and counts up to 15.
	localparam int          MEAN_SHIFT = 16;
	localparam logic [16:0] MEAN_MUL   = 17'((2 ** MEAN_SHIFT + SAMPLE_COUNT - 1) / SAMPLE_COUNT);
	localparam logic [3:0]  KEEP_LIMIT = 4'(SAMPLE_COUNT);

	uer_pkg::uer_phase_t phase_q, phase_d;
	logic [15:0] tick_q, tick_d;
	logic [3:0]  kept_q, kept_d;
	logic [11:0] sum_q, sum_d;
	logic [11:0] quot_q, quot_d;
	logic [5:0]  rem_q, rem_d;

	logic [16:0] tick_inc;
	logic [6:0]  rem_step;
	logic [7:0]  dist_sat;
	logic [11:0] sum_new;
	logic [3:0]  kept_new;
	logic [28:0] mean_prod;
	uer_pkg::uer_phase_t after_attempt;

	assign tick_inc      = {1'b0, tick_q} + 17'd1;
	assign rem_step      = {1'b0, rem_q} + uer_pkg::DIST_STEP;
	assign dist_sat      = (quot_q > {4'd0, cfg.max_dist}) ? cfg.max_dist : quot_q[7:0];
	assign sum_new       = sum_q + {4'd0, dist_sat};
	assign kept_new      = kept_q + 4'd1;
	assign mean_prod     = 29'(sum_new) * 29'(MEAN_MUL);
	assign after_attempt = (cfg.gap == 16'd0) ? uer_pkg::PH_TRIG_LOW : uer_pkg::PH_GAP;

	always_comb begin
		phase_d = phase_q;
		tick_d  = tick_q;
		kept_d  = kept_q;
		sum_d   = sum_q;
		quot_d  = quot_q;
		rem_d   = rem_q;
		result  = '0;
		case (phase_q)
			uer_pkg::PH_TRIG_LOW: begin
				tick_d = tick_inc[15:0];
				if (tick_inc >= {1'b0, cfg.trig_low}) begin
					phase_d = uer_pkg::PH_TRIG_HIGH;
					tick_d  = '0;
				end
			end
			uer_pkg::PH_TRIG_HIGH: begin
				result.trigger_level = 1'b1;
				tick_d = tick_inc[15:0];
				if (tick_inc >= {1'b0, cfg.trig_high}) begin
					phase_d = uer_pkg::PH_WAIT_RISE;
					tick_d  = '0;
				end
			end
			uer_pkg::PH_WAIT_RISE: begin
				if (echo_level) begin
					phase_d = uer_pkg::PH_ECHO_HIGH;
					tick_d  = '0;
					quot_d  = '0;
					rem_d   = '0;
				end else if (tick_q >= cfg.timeout) begin
					result.reading_done = 1'b1;
					phase_d = after_attempt;
					tick_d  = '0;
				end else begin
					tick_d = tick_inc[15:0];
				end
			end
			uer_pkg::PH_ECHO_HIGH: begin
				if (!echo_level) begin
					result.reading_done = 1'b1;
					if (dist_sat != 8'd0) begin
						result.reading_kept = 1'b1;
						result.reading_cm   = dist_sat;
						sum_d  = sum_new;
						kept_d = kept_new;
						if (kept_new >= KEEP_LIMIT) begin
							result.mean_valid = 1'b1;
							result.mean_cm    = mean_prod[MEAN_SHIFT +: 8];
							sum_d  = '0;
							kept_d = '0;
						end
					end
					phase_d = after_attempt;
					tick_d  = '0;
				end else if (tick_q >= cfg.timeout) begin
					result.reading_done = 1'b1;
					phase_d = after_attempt;
					tick_d  = '0;
				end else begin
					// Running quotient of 2*ticks/59, kept one step at a time.
					tick_d = tick_inc[15:0];
					if (rem_step >= uer_pkg::DIST_DIVISOR) begin
						rem_d  = 6'(rem_step - uer_pkg::DIST_DIVISOR);
						quot_d = quot_q + 12'd1;
					end else begin
						rem_d = rem_step[5:0];
					end
				end
			end
			uer_pkg::PH_GAP: begin
				tick_d = tick_inc[15:0];
				if (tick_inc >= {1'b0, cfg.gap}) begin
					phase_d = uer_pkg::PH_TRIG_LOW;
					tick_d  = '0;
				end
			end
			default: begin
				phase_d = uer_pkg::PH_TRIG_LOW;
				tick_d  = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= uer_pkg::PH_TRIG_LOW;
			tick_q  <= '0;
			kept_q  <= '0;
			sum_q   <= '0;
			quot_q  <= '0;
			rem_q   <= '0;
		end else if (advance) begin
			phase_q <= phase_d;
			tick_q  <= tick_d;
			kept_q  <= kept_d;
			sum_q   <= sum_d;
			quot_q  <= quot_d;
			rem_q   <= rem_d;
		end
	end

endmodule
`default_nettype wire

// ===== design/ultrasonic_echo_ranger_core.sv =====
// Ultrasonic echo ranger core.
// Every item on the slave stream is one microsecond tick carrying the sampled echo
// pin level. The block drives the trigger pin (held low, then pulsed high), waits
// for the echo to rise, times the echo width and converts it to centimetres. Every
// accepted item gives exactly one item on the master stream with the trigger level
// for that tick, the finished reading when an attempt ends, and a mean of the last
// SAMPLE_COUNT kept readings when enough of them have been collected.
// Timing: one item per clock cycle sustained while m_tready stays high. The result of an
// item is presented on the master side in the cycle after it is accepted if the output
// register is free; all the work for a tick is done in one pass of logic ahead of that register.
// Stalls: an output register and a one-item skid buffer follow the logic, so
// s_tready stays high while the receiver stalls until the skid holds an item;
// it then falls, and rises again in the cycle after the receiver takes the item
// waiting in the output register.
// Reset: arst_n clears the sequencer to the trigger-low phase with all counters and
// the running sum at zero, empties the output stages and loads the register defaults.
// Configuration registers are written through cfg_we/cfg_index/cfg_wdata and should
// only be changed while no item is in flight.
`default_nettype none
module ultrasonic_echo_ranger_core #(
	parameter int SAMPLE_COUNT = 10
) (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        s_tvalid,
	output logic       s_tready,
	input  wire [7:0]  s_tdata,   // [0] echo_level, [7:1] zero
	output logic       m_tvalid,
	input  wire        m_tready,
	output logic [23:0] m_tdata,  // [0] trigger_level, [1] reading_done, [2] reading_kept,
	                              // [10:3] reading_cm, [11] mean_valid, [19:12] mean_cm,
	                              // [23:20] zero
	input  wire        cfg_we,
	input  wire [2:0]  cfg_index,
	input  wire [15:0] cfg_wdata
);

	uer_pkg::uer_cfg_t    cfg_q;
	uer_pkg::uer_result_t result;
	uer_pkg::uer_result_t out_q;
	uer_pkg::uer_result_t skid_q;
	logic out_valid_q;
	logic skid_valid_q;
	logic accept;
	logic out_free;

	assign s_tready = !skid_valid_q;
	assign accept   = s_tvalid && s_tready;
	// The output register can take a new item when it is empty or being drained.
	assign out_free = !out_valid_q || m_tready;

	// Configuration registers; indexes beyond the list are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.trig_low  <= uer_pkg::RST_TRIG_LOW;
			cfg_q.trig_high <= uer_pkg::RST_TRIG_HIGH;
			cfg_q.timeout   <= uer_pkg::RST_TIMEOUT;
			cfg_q.gap       <= uer_pkg::RST_GAP;
			cfg_q.max_dist  <= uer_pkg::RST_MAX_DIST;
		end else if (cfg_we) begin
			case (cfg_index)
				uer_pkg::CFG_TRIG_LOW:  cfg_q.trig_low  <= cfg_wdata;
				uer_pkg::CFG_TRIG_HIGH: cfg_q.trig_high <= cfg_wdata;
				uer_pkg::CFG_TIMEOUT:   cfg_q.timeout   <= cfg_wdata;
				uer_pkg::CFG_GAP:       cfg_q.gap       <= cfg_wdata;
				uer_pkg::CFG_MAX_DIST:  cfg_q.max_dist  <= cfg_wdata[7:0];
				default: ;
			endcase
		end
	end

	// The sequencer state moves on only when a tick is accepted.
	uer_sequencer #(
		.SAMPLE_COUNT(SAMPLE_COUNT)
	) u_sequencer (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (accept),
		.echo_level(s_tdata[0]),
		.cfg       (cfg_q),
		.result    (result)
	);

	// Output stage control: the skid item always leaves before a fresh one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_free) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= accept;
			end
		end else if (accept) begin
			skid_valid_q <= 1'b1;
		end
	end

	// Output stage payload.
	always_ff @(posedge clk) begin
		if (out_free) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
			end else if (accept) begin
				out_q <= result;
			end
		end else if (accept) begin
			skid_q <= result;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'd0, out_q.mean_cm, out_q.mean_valid, out_q.reading_cm,
		out_q.reading_kept, out_q.reading_done, out_q.trigger_level};

endmodule
`default_nettype wire

// ===== tb/ranger_check_pkg.sv =====
package ranger_check_pkg;
	import uer_pkg::*;

	// Tracks the ranging sequence one tick at a time and holds the result items
	// that the block still owes, oldest first.
	class ranging_scoreboard #(int SAMPLES = 10);
		uer_cfg_t    regs;
		uer_phase_t  phase;
		logic [15:0] tick_count;
		logic [3:0]  kept_count;
		logic [11:0] reading_sum;
		uer_result_t tick_results[$];
		int unsigned failures;
		int unsigned attempts;
		int unsigned means;

		function new();
			regs.trig_low  = 16'd10000;
			regs.trig_high = 16'd10;
			regs.timeout   = 16'd30000;
			regs.gap       = 16'd50000;
			regs.max_dist  = 8'd200;
			phase          = PH_TRIG_LOW;
			tick_count     = '0;
			kept_count     = '0;
			reading_sum    = '0;
			failures       = 0;
			attempts       = 0;
			means          = 0;
		endfunction

		function void write_reg(logic [2:0] index, logic [15:0] value);
			case (index)
			CFG_TRIG_LOW:  regs.trig_low  = value;
			CFG_TRIG_HIGH: regs.trig_high = value;
			CFG_TIMEOUT:   regs.timeout   = value;
			CFG_GAP:       regs.gap       = value;
			CFG_MAX_DIST:  regs.max_dist  = value[7:0];
			default: ;
			endcase
		endfunction

		function void close_attempt();
			tick_count = '0;
			phase = (regs.gap == 16'd0) ? PH_TRIG_LOW : PH_GAP;
		endfunction

		function void note_tick(bit echo);
			uer_result_t r;
			int unsigned range_cm;
			r = '0;
			case (phase)
			PH_TRIG_LOW: begin
				tick_count++;
				if (tick_count >= regs.trig_low) begin
					phase = PH_TRIG_HIGH;
					tick_count = '0;
				end
			end
			PH_TRIG_HIGH: begin
				r.trigger_level = 1'b1;
				tick_count++;
				if (tick_count >= regs.trig_high) begin
					phase = PH_WAIT_RISE;
					tick_count = '0;
				end
			end
			PH_WAIT_RISE: begin
				if (echo) begin
					phase = PH_ECHO_HIGH;
					tick_count = '0;
				end else if (tick_count >= regs.timeout) begin
					r.reading_done = 1'b1;
					close_attempt();
				end else begin
					tick_count++;
				end
			end
			PH_ECHO_HIGH: begin
				if (!echo) begin
					// Width over 29.5 us per centimetre, kept in integers.
					range_cm = (32'(tick_count) * 2) / 59;
					if (range_cm > regs.max_dist)
						range_cm = regs.max_dist;
					r.reading_done = 1'b1;
					if (range_cm != 0) begin
						r.reading_kept = 1'b1;
						r.reading_cm   = range_cm[7:0];
						reading_sum    = reading_sum + range_cm[11:0];
						kept_count     = kept_count + 4'd1;
						if (kept_count >= SAMPLES) begin
							r.mean_valid = 1'b1;
							r.mean_cm    = 8'(reading_sum / SAMPLES);
							reading_sum  = '0;
							kept_count   = '0;
						end
					end
					close_attempt();
				end else if (tick_count >= regs.timeout) begin
					r.reading_done = 1'b1;
					close_attempt();
				end else begin
					tick_count++;
				end
			end
			PH_GAP: begin
				tick_count++;
				if (tick_count >= regs.gap) begin
					phase = PH_TRIG_LOW;
					tick_count = '0;
				end
			end
			default: begin
				phase = PH_TRIG_LOW;
				tick_count = '0;
			end
			endcase
			if (r.reading_done)
				attempts++;
			if (r.mean_valid)
				means++;
			tick_results.push_back(r);
		endfunction

		function void compare(string field, logic [7:0] want, logic [7:0] got);
			if (got !== want) begin
				$error("%s: expected %0d, got %0d", field, want, got);
				failures++;
			end
		endfunction

		function void check_result(logic [23:0] word);
			uer_result_t want;
			uer_result_t got;
			got = uer_result_t'(word[19:0]);
			if (tick_results.size() == 0) begin
				$error("result %h arrived with nothing expected", word);
				failures++;
				return;
			end
			want = tick_results.pop_front();
			compare("trigger_level", 8'(want.trigger_level), 8'(got.trigger_level));
			compare("reading_done", 8'(want.reading_done), 8'(got.reading_done));
			compare("reading_kept", 8'(want.reading_kept), 8'(got.reading_kept));
			compare("reading_cm", want.reading_cm, got.reading_cm);
			compare("mean_valid", 8'(want.mean_valid), 8'(got.mean_valid));
			compare("mean_cm", want.mean_cm, got.mean_cm);
			compare("tdata padding", 8'd0, 8'(word[23:20]));
		endfunction
	endclass

endpackage

// ===== tb/tb_ultrasonic_echo_ranger_core.sv =====
module tb_ultrasonic_echo_ranger_core;
	timeunit 1ns;
	timeprecision 1ps;

	import uer_pkg::*;
	import ranger_check_pkg::*;

	localparam int MEAN_SAMPLES = 10;
	// Far beyond the slowest correct run, even with every idle burst at its longest.
	localparam int unsigned RUN_LIMIT = 100_000;
	// Indexes past the last register; writes there must change nothing.
	localparam logic [2:0] CFG_UNUSED_FIRST = 3'd5;
	localparam logic [2:0] CFG_UNUSED_LAST  = 3'd7;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata   = 8'd0;
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [23:0] m_tdata;
	logic        cfg_we    = 1'b0;
	logic [2:0]  cfg_index = 3'd0;
	logic [15:0] cfg_wdata = 16'd0;

	ranging_scoreboard #(.SAMPLES(MEAN_SAMPLES)) sb;

	// Echo plan for the attempt in progress: low ticks before the rise and high
	// ticks after the rising tick.
	int rise_wait_left;
	int high_left;
	bit attempt_planned = 1'b0;
	// The wide-timeout setting uses a fixed plan with a longer echo.
	bit big_plan        = 1'b0;
	bit sender_idles    = 1'b0;
	bit receiver_idles  = 1'b0;
	int stall_left      = 0;
	int unsigned cycles = 0;
	int random_items;

	ultrasonic_echo_ranger_core #(.SAMPLE_COUNT(MEAN_SAMPLES)) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// The receiver: every result item taken is checked against the oldest
	// expectation. Values are sampled as they stood before the edge, so the
	// order of processes within a time step does not matter. Stalls come in
	// random bursts while receiver idling is enabled.
	always @(posedge clk) begin
		if (m_tvalid && m_tready)
			sb.check_result(m_tdata);
		if (stall_left != 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else if (receiver_idles && $urandom_range(0, 4) == 0) begin
			stall_left = $urandom_range(0, 2);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Watchdog: a hung handshake must not leave the run open.
	always @(posedge clk) begin
		cycles++;
		if (cycles > RUN_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// Offers one tick item and returns at the edge where it is accepted. The
	// valid stays high between back-to-back items, so it is only lowered when
	// an idle burst is really taken.
	task automatic send_tick(input bit echo);
		if (sender_idles && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {7'd0, echo};
		do @(posedge clk); while (!s_tready);
		sb.note_tick(echo);
	endtask

	// Chooses how the next echo should look. Rises and widths sit mostly in a
	// range that gives short, nonzero readings, so that kept readings pile up
	// towards a mean; the rest land on the timeout boundaries on either side
	// and on widths too short to make a centimetre.
	task automatic plan_attempt();
		int t;
		t = int'(sb.regs.timeout);
		if (big_plan) begin
			rise_wait_left = 3;
			high_left      = 100;
		end else begin
			case ($urandom_range(0, 19))
			0:       rise_wait_left = t + 1;
			1:       rise_wait_left = t;
			default: rise_wait_left = $urandom_range(0, 3);
			endcase
			case ($urandom_range(0, 19))
			0:       high_left = t + 1;
			1:       high_left = t;
			2, 3:    high_left = $urandom_range(0, 29);
			default: high_left = $urandom_range(30, 45);
			endcase
		end
		attempt_planned = 1'b1;
	endtask

	// Sends one tick whose echo follows the predicted phase. While the trigger
	// is being driven or the gap runs, the echo is ignored by the block and so
	// is random. While waiting or timing, the echo follows the plan, with the
	// odd flipped sample to break the sequence.
	task automatic drive_tick();
		bit echo;
		case (sb.phase)
		PH_WAIT_RISE, PH_ECHO_HIGH: begin
			if (!attempt_planned)
				plan_attempt();
			if (sb.phase == PH_WAIT_RISE) begin
				if (rise_wait_left != 0) begin
					echo = 1'b0;
					rise_wait_left--;
				end else begin
					echo = 1'b1;
				end
			end else begin
				if (high_left != 0) begin
					echo = 1'b1;
					high_left--;
				end else begin
					echo = 1'b0;
				end
			end
			if (!big_plan && $urandom_range(0, 127) == 0)
				echo = !echo;
		end
		default: begin
			attempt_planned = 1'b0;
			echo = 1'($urandom_range(0, 1));
		end
		endcase
		send_tick(echo);
	endtask

	task automatic write_cfg_reg(input logic [2:0] index, input logic [15:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= index;
		cfg_wdata <= value;
		@(posedge clk);
		sb.write_reg(index, value);
	endtask

	// Registers only change with nothing in flight: every tick gives a result,
	// so an empty queue of expected results means the block is at rest. The
	// distance limit is written with junk in its upper byte, and one unused
	// index is written as well; neither may have any effect.
	task automatic apply_setting(input uer_cfg_t c);
		s_tvalid <= 1'b0;
		while (sb.tick_results.size() != 0) @(posedge clk);
		write_cfg_reg(CFG_TRIG_LOW, c.trig_low);
		write_cfg_reg(CFG_TRIG_HIGH, c.trig_high);
		write_cfg_reg(CFG_TIMEOUT, c.timeout);
		write_cfg_reg(CFG_GAP, c.gap);
		write_cfg_reg(CFG_MAX_DIST, {8'($urandom), c.max_dist});
		write_cfg_reg(3'($urandom_range(CFG_UNUSED_FIRST, CFG_UNUSED_LAST)),
			16'($urandom));
		cfg_we <= 1'b0;
	endtask

	// Short trigger phases and gaps keep attempts cheap. One early setting
	// clamps every distance to nothing and another has a timeout so short that
	// most attempts time out; all the others can complete readings.
	function automatic uer_cfg_t random_setting(int p);
		uer_cfg_t c;
		c.trig_low  = 16'($urandom_range(0, 4));
		c.trig_high = 16'($urandom_range(0, 3));
		c.timeout   = (p == 2) ? 16'($urandom_range(0, 8)) : 16'($urandom_range(50, 64));
		c.gap       = 16'($urandom_range(0, 3));
		c.max_dist  = (p == 1) ? 8'd0 : 8'($urandom_range(1, 4));
		return c;
	endfunction

	initial begin
		uer_cfg_t c;
		bit [0:10] zero_regs_ticks;
		bit [0:10] boundary_ticks;
		int p;

		sb = new();
		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Every register at zero, the distance limit included. Each trigger
		// phase then lasts a single tick, the gap is skipped, and the timeout
		// fires on the first waiting tick. Three attempts: a rise timeout, a
		// width timeout straight after the rise, and an echo that falls at
		// once and so reads zero. Echo highs during the trigger are ignored.
		sender_idles   = 1'b1;
		receiver_idles = 1'b1;
		c = '{trig_low: 16'd0, trig_high: 16'd0, timeout: 16'd0, gap: 16'd0,
			max_dist: 8'd0};
		apply_setting(c);
		zero_regs_ticks = 11'b110_0111_1010;
		for (int i = 0; i < 11; i++)
			send_tick(zero_regs_ticks[i]);

		// Small values: the echo rises on the very tick the timeout is due,
		// stays high for exactly the timeout, reads zero, then a one-tick gap.
		c = '{trig_low: 16'd2, trig_high: 16'd1, timeout: 16'd2, gap: 16'd1,
			max_dist: 8'd1};
		apply_setting(c);
		boundary_ticks = 11'b01_1_001_110_1_0;
		for (int i = 0; i < 11; i++)
			send_tick(boundary_ticks[i]);

		// The widest timeout and distance limit, with one attempt whose echo is
		// longer than any in the random settings, then the gap. Run without
		// idling.
		sender_idles   = 1'b0;
		receiver_idles = 1'b0;
		c = '{trig_low: 16'd3, trig_high: 16'd2, timeout: 16'hFFFF,
			gap: 16'd3, max_dist: 8'd255};
		apply_setting(c);
		big_plan = 1'b1;
		p = sb.attempts;
		do drive_tick(); while (sb.attempts == p || sb.phase != PH_TRIG_LOW);
		big_plan = 1'b0;

		// Random settings in blocks of ticks, each block with its own mix of idling,
		// until enough ticks have gone by and a mean has been produced, or for twenty blocks at most.
		p = 0;
		random_items = 0;
		while ((random_items < 300 || sb.means < 1) && p < 20) begin
			apply_setting(random_setting(p));
			sender_idles   = ($urandom_range(0, 3) != 0);
			receiver_idles = ($urandom_range(0, 3) != 0);
			repeat (60) drive_tick();
			random_items += 60;
			p++;
		end

		// A last stretch at full rate on both sides.
		sender_idles   = 1'b0;
		receiver_idles = 1'b0;
		apply_setting(random_setting(0));
		repeat (100) drive_tick();

		s_tvalid <= 1'b0;
		while (sb.tick_results.size() != 0) @(posedge clk);
		// Waiting on past the last expected result shows up any result item that should never have come.
		repeat (4) @(posedge clk);
		if (sb.failures == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
